// ----- rtl/fbbs_pkg.sv -----
// Shared types, constants and character table for the FSK Baudot bit slicer.
`default_nettype none

package fbbs_pkg;

  localparam int SAMPLE_W    = 32;
  localparam int THRESH_W    = 31;
  localparam int SPB_W       = 20;
  localparam int CODE_W      = 5;
  localparam int CHAR_W      = 8;
  localparam int BITS_W      = 3;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = THRESH_W;
  localparam int OUT_TDATA_W = 24;

  localparam logic [BITS_W-1:0] BITS_PER_CHAR = 3'd5;
  localparam logic [SPB_W-1:0]  SPB_RESET     = 20'd28000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD       = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_BIT = 1'd1;

  // Primary ITA2-style letter table; the alternate table is this one read backward.
  localparam logic [CHAR_W-1:0] LETTER_TABLE [32] = '{
    8'h2E, 8'h45, 8'h0D, 8'h41, 8'h20, 8'h53, 8'h49, 8'h55,
    8'h0A, 8'h44, 8'h52, 8'h4A, 8'h4E, 8'h46, 8'h43, 8'h4B,
    8'h54, 8'h5A, 8'h4C, 8'h57, 8'h48, 8'h59, 8'h50, 8'h51,
    8'h4F, 8'h42, 8'h47, 8'h20, 8'h4D, 8'h58, 8'h56, 8'h3B
  };

  // Outcome of comparing one sample against the threshold band.
  typedef struct packed {
    logic mark;     // sample >= threshold
    logic space;    // sample < -threshold
    logic at_neg;   // sample == -threshold
    logic in_band;  // -threshold < sample < threshold
  } fbbs_level_t;

  typedef struct packed {
    logic [CHAR_W-1:0] alt_letter;
    logic [CHAR_W-1:0] letter;
    logic [CODE_W-1:0] char_code;
  } fbbs_result_t;

  typedef struct packed {
    logic holding;  // output register holds an item
    logic full;     // skid register holds an item too
  } fbbs_buf_status_t;

endpackage

`default_nettype wire

// ----- rtl/fbbs_level_cmp.sv -----
// Threshold band comparator for one discriminator sample.
`default_nettype none

module fbbs_level_cmp
  import fbbs_pkg::*;
(
  input  wire logic signed [SAMPLE_W-1:0] sample,
  input  wire logic        [THRESH_W-1:0] threshold,
  output fbbs_level_t                     level
);

  logic signed [SAMPLE_W:0] s_ext;
  logic signed [SAMPLE_W:0] thr_pos;
  logic signed [SAMPLE_W:0] thr_neg;

  always_comb begin
    s_ext   = (SAMPLE_W+1)'(sample);
    thr_pos = $signed({2'b00, threshold});
    thr_neg = -thr_pos;
    level.mark    = (s_ext >= thr_pos);
    level.space   = (s_ext < thr_neg);
    level.at_neg  = (s_ext == thr_neg);
    level.in_band = (s_ext > thr_neg) && (s_ext < thr_pos);
  end

endmodule

`default_nettype wire

// ----- rtl/fbbs_out_buf.sv -----
// Two-entry output buffer: result register plus skid register.
`default_nettype none

module fbbs_out_buf
  import fbbs_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  fbbs_result_t      push_data,
  output logic              space,
  output logic              out_valid,
  input  wire logic         out_ready,
  output fbbs_result_t      out_data,
  output fbbs_buf_status_t  status
);

  logic         main_valid;
  logic         skid_valid;
  fbbs_result_t main;
  fbbs_result_t skid;
  logic         pop;

  assign pop       = main_valid && out_ready;
  assign space     = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main;
  assign status    = '{holding: main_valid, full: skid_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      if (!main_valid) begin
        main_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        main <= skid;
      end else if (push) begin
        main <= push_data;
      end
    end else if (push) begin
      if (!main_valid) begin
        main <= push_data;
      end else begin
        skid <= push_data;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/fsk_baudot_bit_slicer.sv -----
// Top level of the FSK Baudot bit slicer: state update, configuration and output.
`default_nettype none

// The slave channel takes one discriminator sample per item (mark minus space
// energy, signed, same scale as the threshold). While idle, a sample whose
// magnitude reaches the threshold starts detection; a phase counter then makes
// one bit decision per bit period, at its middle. Five bits make a character,
// first bit in the LSB, and the master channel then carries the code and its
// primary and reversed-table letters. A decision inside the threshold band
// drops detection and discards the partial character.
//
// The state update is a single compare-and-count step, so a sample is accepted
// on every cycle while the output buffer has room. A result is written into the
// output buffer's result or skid register when its last sample is accepted.
// Results pass through a result register backed by a skid register; s_tready
// falls only while both hold items, that is, after the receiver has stalled
// with two characters pending. Samples that produce no result are never lost.
// Reset (rst, synchronous) clears detection, the phase counter, the partial
// character and both buffer entries, and sets threshold to 0 and
// samples_per_bit to 28000. Configuration writes take effect at once and are
// meant for idle periods only.
module fsk_baudot_bit_slicer
  import fbbs_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  // Configuration write port.
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  // Sample channel. s_tdata: sample[31:0].
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [SAMPLE_W-1:0]    s_tdata,
  // Result channel. m_tdata: char_code[4:0], letter[12:5], alt_letter[20:13], zero pad.
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [OUT_TDATA_W-1:0]      m_tdata
);

  logic [THRESH_W-1:0] threshold;
  logic [SPB_W-1:0]    samples_per_bit;

  logic                detecting;
  logic [SPB_W-1:0]    phase_count;
  logic [CODE_W-1:0]   code_bits;
  logic [BITS_W-1:0]   bits_taken;

  logic                detecting_next;
  logic [SPB_W-1:0]    phase_count_next;
  logic [CODE_W-1:0]   code_bits_next;
  logic [BITS_W-1:0]   bits_taken_next;

  logic                accept;
  logic                decide;
  logic [CODE_W-1:0]   code_acc;
  logic [BITS_W-1:0]   taken_acc;
  logic [SPB_W-1:0]    phase_base;
  logic                emit;
  fbbs_level_t         level;
  fbbs_result_t        result;
  fbbs_result_t        out_data;
  fbbs_buf_status_t    buf_status;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold       <= '0;
      samples_per_bit <= SPB_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD:       threshold       <= cfg_data[THRESH_W-1:0];
        REG_SAMPLES_PER_BIT: samples_per_bit <= cfg_data[SPB_W-1:0];
        default: ;
      endcase
    end
  end

  fbbs_level_cmp u_level (
    .sample    ($signed(s_tdata)),
    .threshold (threshold),
    .level     (level)
  );

  assign accept = s_tvalid && s_tready;

  // One step of the slicer for the sample at the input.
  always_comb begin
    detecting_next   = detecting;
    phase_count_next = phase_count;
    code_bits_next   = code_bits;
    bits_taken_next  = bits_taken;
    code_acc         = code_bits;
    taken_acc        = bits_taken;
    phase_base       = phase_count;
    emit             = 1'b0;
    decide           = detecting && (phase_count == {1'b0, samples_per_bit[SPB_W-1:1]});

    if (!detecting) begin
      // Start of detection: the starting sample gives no bit.
      if (level.mark || level.space || level.at_neg) begin
        detecting_next   = 1'b1;
        phase_count_next = SPB_W'(1);
      end
    end else if (decide && level.in_band) begin
      // Weak decision: lose lock and throw the partial character away.
      detecting_next   = 1'b0;
      phase_count_next = '0;
      code_bits_next   = '0;
      bits_taken_next  = '0;
    end else begin
      // A sample exactly at minus threshold takes no bit and keeps running.
      if (decide && level.mark) begin
        code_acc  = code_bits | (CODE_W'(1) << bits_taken);
        taken_acc = bits_taken + BITS_W'(1);
      end else if (decide && level.space) begin
        taken_acc = bits_taken + BITS_W'(1);
      end
      // Wrap at the end of the period, also when the period was shortened.
      if (phase_count >= samples_per_bit) begin
        phase_base = '0;
      end
      phase_count_next = phase_base + SPB_W'(1);
      if (taken_acc >= BITS_PER_CHAR) begin
        emit            = 1'b1;
        code_bits_next  = '0;
        bits_taken_next = '0;
      end else begin
        code_bits_next  = code_acc;
        bits_taken_next = taken_acc;
      end
    end
  end

  always_comb begin
    result.char_code  = code_acc;
    result.letter     = LETTER_TABLE[code_acc];
    result.alt_letter = LETTER_TABLE[~code_acc];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      detecting   <= 1'b0;
      phase_count <= '0;
      code_bits   <= '0;
      bits_taken  <= '0;
    end else if (accept) begin
      detecting   <= detecting_next;
      phase_count <= phase_count_next;
      code_bits   <= code_bits_next;
      bits_taken  <= bits_taken_next;
    end
  end

  fbbs_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && emit),
    .push_data (result),
    .space     (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_data),
    .status    (buf_status)
  );

  assign m_tdata = {3'b000, out_data};

  // The skid register is only used while the result register is occupied.
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    buf_status.full |-> buf_status.holding)
    else $error("skid register holds an item while the result register is empty");

  // A character is only ever produced while detection is running.
  a_emit_needs_lock: assert property (@(posedge clk) disable iff (rst)
    (accept && emit) |-> detecting)
    else $error("character emitted while not detecting");

  // When idle there is no partial character and no phase.
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    !detecting |-> (code_bits == '0 && bits_taken == '0 && phase_count == '0))
    else $error("idle slicer holds stale character or phase");

  // A partial character never reaches the full length between items.
  a_bits_bounded: assert property (@(posedge clk) disable iff (rst)
    bits_taken < BITS_PER_CHAR)
    else $error("partial character count out of range");

  // After a completed character is accepted, the result side presents a valid item in the next cycle.
  a_emit_visible: assert property (@(posedge clk) disable iff (rst)
    (accept && emit) |=> m_tvalid)
    else $error("completed character not presented");

endmodule

`default_nettype wire
